>>> rtl/core/bfsc_pkg.sv
// ----------------------------------------------------------------------------
// bfsc_pkg
// Shared types, codes and tables for the band and filter switch controller.
// ----------------------------------------------------------------------------
package bfsc_pkg;

  localparam int NumBands   = 7;
  localparam int NumWindows = 10;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_PRESS    = 2'd1;
  localparam logic [1:0] OP_BAND_REQ = 2'd2;
  localparam logic [1:0] OP_SET_AUTO = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ADC_TOL    = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_TEMP_ALARM = 2'd2;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam logic [5:0]  ADC_TOL_RST    = 6'd10;
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [9:0]  TEMP_ALARM_RST = 10'd419;

  localparam logic [2:0] BAND_RST  = 3'd0;
  localparam logic [2:0] BAND_LAST = 3'd6;
  localparam logic [2:0] BAND_NONE = 3'd7;

  localparam logic [9:0] WIN_CENTRE [NumWindows] = '{
    10'd65, 10'd140, 10'd207, 10'd269, 10'd337,
    10'd411, 10'd479, 10'd536, 10'd605, 10'd680
  };
  localparam logic [2:0] WIN_BAND [NumWindows] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6
  };

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  cat_adc;
    logic        temp_check;
    logic [9:0]  temp_adc;
    logic        tx_active;
    logic [15:0] press_ms;
    logic [2:0]  band_request;
    logic        auto_request;
  } in_item_t;

  typedef struct packed {
    logic [2:0] band;
    logic [6:0] band_onehot;
    logic [3:0] lpf_code;
    logic       auto_mode;
    logic       temp_alarm;
    logic       band_changed;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  adc_tol;
    logic [15:0] long_press;
    logic [9:0]  temp_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0] band;
    logic       auto_flag;
    logic       alarm_flag;
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] band;
  } win_t;

  function automatic logic [3:0] lpf_of(input logic [2:0] b);
    logic [3:0] c;
    case (b)
      3'd1:    c = 4'h8;
      3'd2:    c = 4'h4;
      3'd3:    c = 4'hC;
      3'd4:    c = 4'hA;
      3'd5:    c = 4'hE;
      3'd6:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/bfsc_win_decode.sv
// ----------------------------------------------------------------------------
// bfsc_win_decode
// Voltage window decoder: parallel window compares, first match wins.
// ----------------------------------------------------------------------------
module bfsc_win_decode (
  input  logic [9:0]    sample,
  input  logic [5:0]    tol,
  output bfsc_pkg::win_t win
);
  import bfsc_pkg::*;

  logic [NumWindows-1:0] match;
  logic [10:0]           s_plus_t;

  assign s_plus_t = {1'b0, sample} + {5'd0, tol};

  // c - t < s < c + t, written without negative values
  always_comb begin
    for (int i = 0; i < NumWindows; i++) begin
      match[i] = (s_plus_t > {1'b0, WIN_CENTRE[i]}) &&
                 ({1'b0, sample} < ({1'b0, WIN_CENTRE[i]} + {5'd0, tol}));
    end
  end

  always_comb begin
    win.hit  = |match;
    win.band = BAND_NONE;
    for (int i = NumWindows - 1; i >= 0; i--) begin
      if (match[i]) begin
        win.band = WIN_BAND[i];
      end
    end
  end

endmodule

>>> rtl/core/bfsc_update.sv
// ----------------------------------------------------------------------------
// bfsc_update
// Next-state logic for band, automatic mode and temperature alarm.
// ----------------------------------------------------------------------------
module bfsc_update (
  input  bfsc_pkg::in_item_t item,
  input  bfsc_pkg::cfg_t     cfg,
  input  bfsc_pkg::state_t   st,
  input  bfsc_pkg::win_t     win,
  output bfsc_pkg::state_t   st_nxt
);
  import bfsc_pkg::*;

  logic       alarm_now;
  logic [2:0] band_step;

  assign alarm_now = item.temp_adc >= cfg.temp_code;
  assign band_step = (st.band >= BAND_LAST) ? 3'd0 : st.band + 3'd1;

  always_comb begin
    st_nxt = st;
    case (item.op)
      OP_TICK: begin
        if (item.temp_check) begin
          st_nxt.alarm_flag = alarm_now;
        end
        if (!(item.temp_check && alarm_now) && st.auto_flag && win.hit &&
            !item.tx_active) begin
          st_nxt.band = win.band;
        end
      end
      OP_PRESS: begin
        if (item.press_ms > cfg.long_press) begin
          st_nxt.auto_flag = !st.auto_flag;
        end else if (!st.auto_flag && !item.tx_active) begin
          st_nxt.band = band_step;
        end
      end
      OP_BAND_REQ: begin
        if (!item.tx_active && item.band_request != BAND_NONE) begin
          st_nxt.band = item.band_request;
        end
      end
      default: begin
        st_nxt.auto_flag = item.auto_request;
      end
    endcase
  end

endmodule

>>> rtl/core/band_filter_switch_controller.sv
// ----------------------------------------------------------------------------
// band_filter_switch_controller
// Band and low-pass filter switch controller with voltage band decode.
// ----------------------------------------------------------------------------
// Every accepted beat gives exactly one result beat, through the input
// register and then the result register. One beat is taken per cycle while
// the output is not stalled: the input register feeds a single state-update
// stage (window decode plus band/flag update) that writes the result
// register. Configuration registers reset to tolerance 10, long press 2000 and
// temperature alarm code 419; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module band_filter_switch_controller (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  bfsc_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output bfsc_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [bfsc_pkg::CfgAddrW-1:0]         cfg_addr,
  input  logic [bfsc_pkg::CfgDataW-1:0]         cfg_wdata
);
  import bfsc_pkg::*;

  cfg_t      cfg_r;
  state_t    st_r;
  state_t    st_nxt;
  win_t      win;
  in_item_t  in_data_r;
  logic      in_vld_r;
  logic      in_vld_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      out_vld_r;
  logic      out_vld_nxt;
  logic      adv;
  logic      in_acc;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign in_vld_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_vld_r && !out_stall ? 1'b0 : out_vld_r);

  bfsc_win_decode u_dec (
    .sample (in_data_r.cat_adc),
    .tol    (cfg_r.adc_tol),
    .win    (win)
  );

  bfsc_update u_upd (
    .item   (in_data_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .win    (win),
    .st_nxt (st_nxt)
  );

  always_comb begin
    out_data_nxt.band         = st_nxt.band;
    out_data_nxt.band_onehot  = 7'(8'd1 << st_nxt.band);
    out_data_nxt.lpf_code     = lpf_of(st_nxt.band);
    out_data_nxt.auto_mode    = st_nxt.auto_flag;
    out_data_nxt.temp_alarm   = st_nxt.alarm_flag;
    out_data_nxt.band_changed = st_nxt.band != st_r.band;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      st_r.band         <= BAND_RST;
      st_r.auto_flag    <= 1'b1;
      st_r.alarm_flag   <= 1'b0;
      cfg_r.adc_tol     <= ADC_TOL_RST;
      cfg_r.long_press  <= LONG_PRESS_RST;
      cfg_r.temp_code   <= TEMP_ALARM_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ADC_TOL:    cfg_r.adc_tol    <= cfg_wdata[5:0];
          REG_LONG_PRESS: cfg_r.long_press <= cfg_wdata;
          REG_TEMP_ALARM: cfg_r.temp_code  <= cfg_wdata[9:0];
          default: ;
        endcase
      end
    end
  end

  // payload beats
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_band_valid: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.band != BAND_NONE)
    else $error("band state out of range");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot(out_data_r.band_onehot))
    else $error("band select not one-hot");

  a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_data_r.tx_active) |=> !out_data_r.band_changed)
    else $error("band changed while transmitting");

  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("held beat dropped");

endmodule

>>> tb/band_filter_switch_controller_tb.sv
// ----------------------------------------------------------------------------
// band_filter_switch_controller_tb
// Self-checking bench for the band and filter switch controller. A local
// predictor tracks band, mode and alarm state per accepted input beat and
// every result beat is compared against it in order. Directed cases cover
// voltage decode, temperature check, button, band request and mode writes;
// random traffic then runs under several register settings and stall mixes.
// ----------------------------------------------------------------------------
module band_filter_switch_controller_tb;
  import bfsc_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  // predicted block state and register copies
  logic [2:0]  cur_band;
  logic        auto_on;
  logic        overheat;
  logic [5:0]  win_tol;
  logic [15:0] long_press_limit;
  logic [9:0]  alarm_code;

  out_item_t pending_results[$];
  int        mismatch_count;
  int        quiet_cycles;
  int        sender_idle_pct;
  int        receiver_stall_pct;

  band_filter_switch_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int window_mid(input int i);
    case (i)
      0: return 65;
      1: return 140;
      2: return 207;
      3: return 269;
      4: return 337;
      5: return 411;
      6: return 479;
      7: return 536;
      8: return 605;
      default: return 680;
    endcase
  endfunction

  function automatic int window_band(input int i);
    case (i)
      0: return 0;
      1: return 1;
      2: return 2;
      3, 4: return 3;
      5, 6: return 4;
      7, 8: return 5;
      default: return 6;
    endcase
  endfunction

  function automatic logic [3:0] filter_bits(input logic [2:0] b);
    case (b)
      3'd1: return 4'h8;
      3'd2: return 4'h4;
      3'd3: return 4'hC;
      3'd4: return 4'hA;
      3'd5: return 4'hE;
      3'd6: return 4'h9;
      default: return 4'h0;
    endcase
  endfunction

  // first matching window wins, -1 when none matches
  function automatic int band_from_voltage(input logic [9:0] sample);
    int i;
    int s;
    int t;
    s = int'(sample);
    t = int'(win_tol);
    for (i = 0; i < NumWindows; i++) begin
      if (s > window_mid(i) - t && s < window_mid(i) + t) return window_band(i);
    end
    return -1;
  endfunction

  function automatic out_item_t predict_switch(input in_item_t it);
    out_item_t  r;
    logic [2:0] prev;
    logic       skip;
    int         target;
    prev = cur_band;
    target = -1;
    skip = 1'b0;
    case (it.op)
      OP_TICK: begin
        if (it.temp_check) begin
          overheat = (it.temp_adc >= alarm_code);
          skip = overheat;
        end
        if (!skip && auto_on) target = band_from_voltage(it.cat_adc);
      end
      OP_PRESS: begin
        if (it.press_ms > long_press_limit) auto_on = !auto_on;
        else if (!auto_on) target = (cur_band == BAND_LAST) ? 0 : int'(cur_band) + 1;
      end
      OP_BAND_REQ: target = int'(it.band_request);
      OP_SET_AUTO: auto_on = it.auto_request;
      default: ;
    endcase
    if (target >= 0 && target < NumBands && !it.tx_active) cur_band = 3'(target);
    r.band         = cur_band;
    r.band_onehot  = 7'(1 << cur_band);
    r.lpf_code     = filter_bits(cur_band);
    r.auto_mode    = auto_on;
    r.temp_alarm   = overheat;
    r.band_changed = (cur_band != prev);
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input int cat, input bit tchk,
                                         input int tadc, input bit tx, input int press,
                                         input int breq, input bit areq);
    in_item_t it;
    it.op           = op;
    it.cat_adc      = 10'(cat);
    it.temp_check   = tchk;
    it.temp_adc     = 10'(tadc);
    it.tx_active    = tx;
    it.press_ms     = 16'(press);
    it.band_request = 3'(breq);
    it.auto_request = areq;
    return it;
  endfunction

  function automatic in_item_t random_switch_item();
    in_item_t it;
    int       v;
    int       tw;
    it.op           = 2'($urandom_range(0, 3));
    it.cat_adc      = 10'($urandom_range(0, 1023));
    it.temp_check   = 1'($urandom_range(0, 1));
    it.temp_adc     = 10'($urandom_range(0, 1023));
    it.tx_active    = 1'($urandom_range(0, 1));
    it.press_ms     = 16'($urandom_range(0, 65535));
    it.band_request = 3'($urandom_range(0, 7));
    it.auto_request = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 80) begin
      // mostly sensible traffic: samples near window edges, codes near limits
      tw = int'(win_tol);
      it.tx_active = ($urandom_range(0, 99) < 15);
      v = int'($urandom_range(0, 9));
      it.op = (v < 5) ? OP_TICK : (v < 7) ? OP_PRESS : (v < 9) ? OP_BAND_REQ : OP_SET_AUTO;
      v = window_mid(int'($urandom_range(0, 9))) + int'($urandom_range(0, 2 * tw + 2)) - tw - 1;
      it.cat_adc = 10'(v);
      it.temp_check = ($urandom_range(0, 3) == 0);
      v = int'(alarm_code) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      it.temp_adc = 10'(v);
      if ($urandom_range(0, 1) == 1) begin
        v = int'(long_press_limit) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        it.press_ms = 16'(v);
      end
      it.auto_request = ($urandom_range(0, 9) < 7);
    end
    return it;
  endfunction

  function automatic string show_result(input out_item_t r);
    return $sformatf("band=%0d onehot=%b lpf=%h auto=%b alarm=%b changed=%b",
                     r.band, r.band_onehot, r.lpf_code, r.auto_mode, r.temp_alarm,
                     r.band_changed);
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  task automatic send_switch_beat(input in_item_t it);
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_switch(it));
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ADC_TOL:    win_tol = val[5:0];
      REG_LONG_PRESS: long_press_limit = val;
      REG_TEMP_ALARM: alarm_code = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int tol, input int lp, input int tc);
    settle_block();
    write_setting(REG_ADC_TOL, CfgDataW'(tol));
    write_setting(REG_LONG_PRESS, CfgDataW'(lp));
    write_setting(REG_TEMP_ALARM, CfgDataW'(tc));
  endtask

  task automatic test_voltage_decode();
    send_switch_beat(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 140, 0, 0, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 1023, 0, 1023, 0, 65535, 7, 1));
    send_switch_beat(make_item(OP_TICK, 680, 0, 0, 1, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 479, 0, 0, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 75, 0, 0, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 74, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_temperature_check();
    send_switch_beat(make_item(OP_TICK, 680, 1, 419, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 680, 1, 418, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_TICK, 65, 1, 1023, 0, 0, 0, 0));
  endtask

  task automatic test_button_press();
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 0, 65535, 0, 0));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 0, 2000, 0, 0));
    send_switch_beat(make_item(OP_TICK, 680, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_band_request();
    send_switch_beat(make_item(OP_BAND_REQ, 0, 0, 0, 0, 0, 7, 0));
    send_switch_beat(make_item(OP_BAND_REQ, 0, 0, 0, 0, 0, 6, 0));
    send_switch_beat(make_item(OP_BAND_REQ, 0, 0, 0, 0, 0, 6, 0));
    send_switch_beat(make_item(OP_BAND_REQ, 0, 0, 0, 1, 0, 2, 0));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 1, 0, 0, 0));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_auto_mode_write();
    send_switch_beat(make_item(OP_SET_AUTO, 0, 0, 0, 1, 0, 0, 1));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 0, 100, 0, 0));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 1, 2001, 0, 0));
    send_switch_beat(make_item(OP_SET_AUTO, 0, 0, 0, 0, 0, 0, 1));
  endtask

  task automatic test_register_extremes();
    apply_settings(0, 0, 0);
    send_switch_beat(make_item(OP_TICK, 65, 0, 0, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 0, 1, 0, 0));
    send_switch_beat(make_item(OP_TICK, 65, 1, 0, 0, 0, 0, 0));
    apply_settings(63, 65535, 1023);
    send_switch_beat(make_item(OP_SET_AUTO, 0, 0, 0, 0, 0, 0, 1));
    send_switch_beat(make_item(OP_TICK, 100, 1, 1022, 0, 0, 0, 0));
    send_switch_beat(make_item(OP_PRESS, 0, 0, 0, 0, 65535, 0, 0));
  endtask

  task automatic test_random_traffic();
    int p;
    int s;
    int n;
    for (p = 0; p < 3; p++) begin
      sender_idle_pct    = (p == 0) ? 23 : (p == 1) ? 84 : 0;
      receiver_stall_pct = (p == 0) ? 84 : (p == 1) ? 23 : 0;
      for (s = 0; s < 3; s++) begin
        case (p * 3 + s)
          0: apply_settings(int'(ADC_TOL_RST), int'(LONG_PRESS_RST), int'(TEMP_ALARM_RST));
          1: apply_settings(0, 0, 0);
          2: apply_settings(63, 65535, 1023);
          3: apply_settings($urandom_range(0, 63), $urandom_range(0, 4000),
                            $urandom_range(0, 1023));
          4: apply_settings(63, 0, 419);
          5: apply_settings(0, 65535, 0);
          7: apply_settings(1, 1, 1022);
          default: apply_settings($urandom_range(0, 63), $urandom_range(0, 65535),
                                  $urandom_range(0, 1023));
        endcase
        for (n = 0; n < 210; n++) send_switch_beat(random_switch_item());
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    string     diff;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure({"unexpected result beat: ", show_result(out_data)});
      end else begin
        want = pending_results.pop_front();
        diff = "";
        if (out_data.band !== want.band) diff = {diff, " band"};
        if (out_data.band_onehot !== want.band_onehot) diff = {diff, " band_onehot"};
        if (out_data.lpf_code !== want.lpf_code) diff = {diff, " lpf_code"};
        if (out_data.auto_mode !== want.auto_mode) diff = {diff, " auto_mode"};
        if (out_data.temp_alarm !== want.temp_alarm) diff = {diff, " temp_alarm"};
        if (out_data.band_changed !== want.band_changed) diff = {diff, " band_changed"};
        if (diff != "") begin
          note_failure($sformatf("mismatch in%s: expected %s, got %s", diff,
                                 show_result(want), show_result(out_data)));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_stall          = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 23;
    receiver_stall_pct = 84;
    cur_band           = BAND_RST;
    auto_on            = 1'b1;
    overheat           = 1'b0;
    win_tol            = ADC_TOL_RST;
    long_press_limit   = LONG_PRESS_RST;
    alarm_code         = TEMP_ALARM_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_voltage_decode();
    test_temperature_check();
    test_button_press();
    test_band_request();
    test_auto_mode_write();
    test_register_extremes();
    test_random_traffic();

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bfsc_pkg.sv
rtl/core/bfsc_win_decode.sv
rtl/core/bfsc_update.sv
rtl/core/band_filter_switch_controller.sv
tb/band_filter_switch_controller_tb.sv
